### hw/rtl/hris_pkg.sv
// Package for the HID report idle scheduler: widths, timing constants,
// register indexes and the structs that carry a poll request and its result.
// No dependencies.
package hris_pkg;

    // Timer ticks per millisecond and the keyboard report width in use.
    localparam int TICKS_PER_MS         = 250;
    localparam int KEYBOARD_REPORT_BITS = 64;

    // Field widths.
    localparam int TICK_W   = 16;
    localparam int KBD_W    = 64;
    localparam int MOUSE_W  = 32;
    localparam int RATE_W   = 8;
    localparam int IDLE_W   = 10;
    localparam int MILLIS_W = 9;
    localparam int REM_W    = 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = RATE_W;
    localparam logic [CFG_INDEX_W-1:0] REG_KEYBOARD_IDLE_RATE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_IDLE_RATE    = 1'd1;

    // Divide by TICKS_PER_MS as a multiply by a rounded-up reciprocal.
    // With this shift the quotient is exact for every 16-bit dividend.
    localparam int RECIP_SHIFT = TICK_W + $clog2(TICKS_PER_MS);
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = TICK_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TICKS_PER_MS) - 64'd1) / 64'(TICKS_PER_MS));

    // Keyboard report bits that take part in the change compare.
    localparam logic [KBD_W-1:0] KBD_MASK = (KEYBOARD_REPORT_BITS >= KBD_W) ? {KBD_W{1'b1}} :
        ((64'd1 << KEYBOARD_REPORT_BITS) - 64'd1);

    // One poll request as held in the input register.
    typedef struct packed {
        logic [TICK_W-1:0] tick_delta;
        logic [KBD_W-1:0]  keyboard_report;
        logic [7:0]        mouse_buttons;
        logic [7:0]        mouse_dx;
        logic [7:0]        mouse_dy;
        logic [7:0]        mouse_scroll;
        logic              keyboard_endpoint_ready;
        logic              mouse_endpoint_ready;
    } t_poll_item;

    // One result as held in the output register.
    typedef struct packed {
        logic                keyboard_send;
        logic [KBD_W-1:0]    keyboard_payload;
        logic                mouse_send;
        logic [MOUSE_W-1:0]  mouse_payload;
        logic [MILLIS_W-1:0] millis_increment;
    } t_report_result;

endpackage

### hw/rtl/hid_report_idle_scheduler_core.sv
// Top level of the HID report idle scheduler: input register, scheduling
// logic with its state, and the result register.
// Depends on hris_pkg.
//
//   Channel  Direction  Handshake                Payload
//   poll     in         i_in_valid / o_in_stall  ticks, reports, endpoint ready bits
//   report   out        o_out_valid / i_out_stall  send flags, payloads, millis
//   config   in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// A request enters the input register, then passes through the scheduling
// logic into the result register. A new request can be taken every cycle
// while the output is not stalled; the rate is set by the single pass of the
// tick divide and the report compares. Reset clears the idle rates, timers,
// pending flags and the held and previous reports. A stalled result holds
// the output register, and the input register then fills and stalls the input.
module hid_report_idle_scheduler_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [hris_pkg::TICK_W-1:0]     i_tick_delta,
    input  logic [hris_pkg::KBD_W-1:0]      i_keyboard_report,
    input  logic [7:0]                      i_mouse_buttons,
    input  logic signed [7:0]               i_mouse_dx,
    input  logic signed [7:0]               i_mouse_dy,
    input  logic signed [7:0]               i_mouse_scroll,
    input  logic                            i_keyboard_endpoint_ready,
    input  logic                            i_mouse_endpoint_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_keyboard_send,
    output logic [hris_pkg::KBD_W-1:0]      o_keyboard_payload,
    output logic                            o_mouse_send,
    output logic [hris_pkg::MOUSE_W-1:0]    o_mouse_payload,
    output logic [hris_pkg::MILLIS_W-1:0]   o_millis_increment,
    input  logic                            i_cfg_we,
    input  logic [hris_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hris_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hris_pkg::*;

    // Pipeline control and payload registers.
    logic           r_in_vld;
    t_poll_item     r_in;
    logic           r_out_vld;
    t_report_result r_out;
    logic           w_out_free;
    logic           w_advance;
    logic           w_accept;

    // Configuration and scheduler state.
    logic [RATE_W-1:0]  r_kbd_rate;
    logic [RATE_W-1:0]  r_mouse_rate;
    logic [REM_W-1:0]   r_tick_rem;
    logic [IDLE_W-1:0]  r_kbd_left;
    logic [IDLE_W-1:0]  r_mouse_left;
    logic               r_kbd_pending;
    logic               r_mouse_pending;
    logic [KBD_W-1:0]   r_kbd_held;
    logic [KBD_W-1:0]   r_kbd_prev;
    logic [MOUSE_W-1:0] r_mouse_held;
    logic [MOUSE_W-1:0] r_mouse_prev;

    logic [REM_W-1:0]   n_tick_rem;
    logic [IDLE_W-1:0]  n_kbd_left;
    logic [IDLE_W-1:0]  n_mouse_left;
    logic               n_kbd_pending;
    logic               n_mouse_pending;
    logic [KBD_W-1:0]   n_kbd_held;
    logic [KBD_W-1:0]   n_kbd_prev;
    logic [MOUSE_W-1:0] n_mouse_held;
    logic [MOUSE_W-1:0] n_mouse_prev;
    t_report_result     n_out;

    // Handshake: the result register frees when it is empty or being taken.
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_advance  = r_in_vld && w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_vld && !w_out_free;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.tick_delta              <= i_tick_delta;
            r_in.keyboard_report         <= i_keyboard_report;
            r_in.mouse_buttons           <= i_mouse_buttons;
            r_in.mouse_dx                <= i_mouse_dx;
            r_in.mouse_dy                <= i_mouse_dy;
            r_in.mouse_scroll            <= i_mouse_scroll;
            r_in.keyboard_endpoint_ready <= i_keyboard_endpoint_ready;
            r_in.mouse_endpoint_ready    <= i_mouse_endpoint_ready;
        end
    end

    // Configuration writes; an index outside the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbd_rate   <= '0;
            r_mouse_rate <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEYBOARD_IDLE_RATE: r_kbd_rate   <= i_cfg_data;
                REG_MOUSE_IDLE_RATE:    r_mouse_rate <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Scheduling logic for the request in the input register.
    always_comb begin
        logic [TICK_W:0]    sum_wide;
        logic [TICK_W-1:0]  sum;
        logic [PROD_W-1:0]  prod;
        logic [TICK_W-1:0]  ms;
        logic [TICK_W-1:0]  rem;
        logic [TICK_W-1:0]  kbd_left_wide;
        logic [TICK_W-1:0]  mouse_left_wide;
        logic [KBD_W-1:0]   kbd_now;
        logic [MOUSE_W-1:0] mouse_now;
        logic               moved;

        // Ticks plus the kept remainder, saturated, then split into whole
        // milliseconds and a new remainder.
        sum_wide = {1'b0, r_in.tick_delta} + (TICK_W+1)'(r_tick_rem);
        sum      = sum_wide[TICK_W] ? {TICK_W{1'b1}} : sum_wide[TICK_W-1:0];
        prod     = PROD_W'(sum) * PROD_W'(RECIP);
        ms       = TICK_W'(prod >> RECIP_SHIFT);
        rem      = sum - TICK_W'(ms * TICK_W'(TICKS_PER_MS));
        n_tick_rem = rem[REM_W-1:0];

        // Count both idle timers down, stopping at zero.
        kbd_left_wide   = TICK_W'(r_kbd_left);
        mouse_left_wide = TICK_W'(r_mouse_left);
        n_kbd_left   = (ms >= kbd_left_wide) ? '0 : r_kbd_left - ms[IDLE_W-1:0];
        n_mouse_left = (ms >= mouse_left_wide) ? '0 : r_mouse_left - ms[IDLE_W-1:0];

        n_out = '0;
        n_out.millis_increment = ms[MILLIS_W-1:0];

        // Keyboard: take a changed report, else repeat on idle timeout.
        kbd_now       = r_in.keyboard_report & KBD_MASK;
        n_kbd_pending = r_kbd_pending;
        n_kbd_held    = r_kbd_held;
        n_kbd_prev    = r_kbd_prev;
        if (!r_kbd_pending) begin
            n_kbd_held = kbd_now;
            if (kbd_now != r_kbd_prev) begin
                n_kbd_prev    = kbd_now;
                n_kbd_pending = 1'b1;
            end
        end
        if (!n_kbd_pending && r_kbd_rate != '0 && n_kbd_left == '0) begin
            n_kbd_held    = n_kbd_prev;
            n_kbd_pending = 1'b1;
        end
        if (n_kbd_pending && r_in.keyboard_endpoint_ready) begin
            n_out.keyboard_send    = 1'b1;
            n_out.keyboard_payload = n_kbd_held;
            n_kbd_pending          = 1'b0;
            n_kbd_left             = {r_kbd_rate, 2'b00};
        end

        // Mouse: same scheme, and any movement with no report pending makes one pending.
        mouse_now = {r_in.mouse_scroll, r_in.mouse_dy, r_in.mouse_dx, r_in.mouse_buttons};
        moved     = (r_in.mouse_dx != '0) || (r_in.mouse_dy != '0) ||
                    (r_in.mouse_scroll != '0);
        n_mouse_pending = r_mouse_pending;
        n_mouse_held    = r_mouse_held;
        n_mouse_prev    = r_mouse_prev;
        if (!r_mouse_pending) begin
            n_mouse_held = mouse_now;
            if (mouse_now != r_mouse_prev) begin
                n_mouse_prev    = mouse_now;
                n_mouse_pending = 1'b1;
            end
            if (moved) begin
                n_mouse_pending = 1'b1;
            end
        end
        if (!n_mouse_pending && r_mouse_rate != '0 && n_mouse_left == '0) begin
            n_mouse_held    = n_mouse_prev;
            n_mouse_pending = 1'b1;
        end
        if (n_mouse_pending && r_in.mouse_endpoint_ready) begin
            n_out.mouse_send    = 1'b1;
            n_out.mouse_payload = n_mouse_held;
            n_mouse_pending     = 1'b0;
            n_mouse_left        = {r_mouse_rate, 2'b00};
        end
    end

    // Scheduler state advances once per request, as it leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rem      <= '0;
            r_kbd_left      <= '0;
            r_mouse_left    <= '0;
            r_kbd_pending   <= 1'b0;
            r_mouse_pending <= 1'b0;
            r_kbd_held      <= '0;
            r_kbd_prev      <= '0;
            r_mouse_held    <= '0;
            r_mouse_prev    <= '0;
        end else if (w_advance) begin
            r_tick_rem      <= n_tick_rem;
            r_kbd_left      <= n_kbd_left;
            r_mouse_left    <= n_mouse_left;
            r_kbd_pending   <= n_kbd_pending;
            r_mouse_pending <= n_mouse_pending;
            r_kbd_held      <= n_kbd_held;
            r_kbd_prev      <= n_kbd_prev;
            r_mouse_held    <= n_mouse_held;
            r_mouse_prev    <= n_mouse_prev;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_keyboard_send    = r_out.keyboard_send;
    assign o_keyboard_payload = r_out.keyboard_payload;
    assign o_mouse_send       = r_out.mouse_send;
    assign o_mouse_payload    = r_out.mouse_payload;
    assign o_millis_increment = r_out.millis_increment;

endmodule

### hw/rtl/hris_checker.sv
// Port-level checker for the HID report idle scheduler, and the bind that
// attaches it to the top level.
// Depends on hid_report_idle_scheduler_core.
module hris_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_keyboard_send,
    input logic [63:0] o_keyboard_payload,
    input logic        o_mouse_send,
    input logic [31:0] o_mouse_payload,
    input logic [8:0]  o_millis_increment
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_keyboard_send) &&
        $stable(o_keyboard_payload) && $stable(o_mouse_send) &&
        $stable(o_mouse_payload) && $stable(o_millis_increment))
        else $error("stalled result changed");

    // The input side only stalls while a finished result is held back.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // A payload is zero unless its report is sent.
    a_kbd_idle_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_keyboard_send |-> o_keyboard_payload == 64'd0)
        else $error("keyboard payload without send");

    a_mouse_idle_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_mouse_send |-> o_mouse_payload == 32'd0)
        else $error("mouse payload without send");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind hid_report_idle_scheduler_core hris_checker u_hris_checker (.*);

### bench/idle_report_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the HID report idle scheduler bench: tracks the scheduler
// state, predicts one result per accepted poll request and checks results.
// Depends on hris_pkg.
package idle_report_scoreboard_pkg;

    import hris_pkg::*;

    // Milliseconds in one unit of an idle rate.
    localparam int MS_PER_RATE_UNIT = 4;
    localparam int TICK_SUM_MAX     = 65535;

    class idle_report_scoreboard;

        // Shadow copy of the configuration and of the scheduler state.
        logic [RATE_W-1:0]  kbd_rate;
        logic [RATE_W-1:0]  mouse_rate;
        logic [REM_W-1:0]   tick_rem;
        logic [IDLE_W-1:0]  kbd_left;
        logic [IDLE_W-1:0]  mouse_left;
        bit                 kbd_pend;
        bit                 mouse_pend;
        logic [KBD_W-1:0]   kbd_held;
        logic [KBD_W-1:0]   kbd_prev;
        logic [MOUSE_W-1:0] mouse_held;
        logic [MOUSE_W-1:0] mouse_prev;

        t_report_result expected_reports[$];
        int             failures;

        function new();
            kbd_rate   = '0;
            mouse_rate = '0;
            tick_rem   = '0;
            kbd_left   = '0;
            mouse_left = '0;
            kbd_pend   = 1'b0;
            mouse_pend = 1'b0;
            kbd_held   = '0;
            kbd_prev   = '0;
            mouse_held = '0;
            mouse_prev = '0;
            failures   = 0;
        endfunction

        function void set_rate(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_KEYBOARD_IDLE_RATE: kbd_rate = value;
                REG_MOUSE_IDLE_RATE: mouse_rate = value;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        // Advance the shadow state by one accepted request and queue its result.
        function void note_poll(t_poll_item p);
            int unsigned        tick_sum;
            int unsigned        ms;
            logic [KBD_W-1:0]   kbd_now;
            logic [MOUSE_W-1:0] mouse_now;
            t_report_result     r;

            // Ticks to whole milliseconds; the sum saturates at the 16-bit top.
            tick_sum = int'(p.tick_delta) + int'(tick_rem);
            if (tick_sum > TICK_SUM_MAX) begin
                tick_sum = TICK_SUM_MAX;
            end
            ms       = tick_sum / TICKS_PER_MS;
            tick_rem = REM_W'(tick_sum % TICKS_PER_MS);

            // Both idle timers run down by the full count and stop at zero.
            kbd_left   = (ms >= kbd_left) ? '0 : kbd_left - IDLE_W'(ms);
            mouse_left = (ms >= mouse_left) ? '0 : mouse_left - IDLE_W'(ms);

            r = '0;
            r.millis_increment = MILLIS_W'(ms);

            // Keyboard: take a changed report, else repeat once the timer runs out.
            kbd_now = p.keyboard_report & KBD_MASK;
            if (!kbd_pend) begin
                kbd_held = kbd_now;
                if (kbd_held != kbd_prev) begin
                    kbd_prev = kbd_held;
                    kbd_pend = 1'b1;
                end
            end
            if (!kbd_pend && kbd_rate != '0 && kbd_left == '0) begin
                kbd_held = kbd_prev;
                kbd_pend = 1'b1;
            end
            if (kbd_pend && p.keyboard_endpoint_ready) begin
                r.keyboard_send    = 1'b1;
                r.keyboard_payload = kbd_held;
                kbd_pend           = 1'b0;
                kbd_left           = IDLE_W'(kbd_rate * MS_PER_RATE_UNIT);
            end

            // Mouse: same scheme, but any movement with no report pending makes one pending.
            mouse_now = {p.mouse_scroll, p.mouse_dy, p.mouse_dx, p.mouse_buttons};
            if (!mouse_pend) begin
                mouse_held = mouse_now;
                if (mouse_held != mouse_prev) begin
                    mouse_prev = mouse_held;
                    mouse_pend = 1'b1;
                end
                if (p.mouse_dx != '0 || p.mouse_dy != '0 || p.mouse_scroll != '0) begin
                    mouse_pend = 1'b1;
                end
            end
            if (!mouse_pend && mouse_rate != '0 && mouse_left == '0) begin
                mouse_held = mouse_prev;
                mouse_pend = 1'b1;
            end
            if (mouse_pend && p.mouse_endpoint_ready) begin
                r.mouse_send    = 1'b1;
                r.mouse_payload = mouse_held;
                mouse_pend      = 1'b0;
                mouse_left      = IDLE_W'(mouse_rate * MS_PER_RATE_UNIT);
            end

            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %h, actual %h", name, want, got);
                failures++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_report(t_report_result got);
            t_report_result want;

            if (expected_reports.size() == 0) begin
                $error("result with no request waiting: keyboard_send %b mouse_send %b",
                       got.keyboard_send, got.mouse_send);
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("keyboard_send", 64'(want.keyboard_send), 64'(got.keyboard_send));
            compare_field("keyboard_payload", want.keyboard_payload, got.keyboard_payload);
            compare_field("mouse_send", 64'(want.mouse_send), 64'(got.mouse_send));
            compare_field("mouse_payload", 64'(want.mouse_payload), 64'(got.mouse_payload));
            compare_field("millis_increment", 64'(want.millis_increment),
                          64'(got.millis_increment));
        endfunction

    endclass

endpackage

### bench/tb_hid_report_idle_scheduler_core.sv
`timescale 1ns / 100ps
// Top-level bench for hid_report_idle_scheduler_core: directed and random poll
// requests under random stalls, checked against the scoreboard's prediction.
// Depends on hris_pkg and idle_report_scoreboard_pkg.
module tb_hid_report_idle_scheduler_core;

    import hris_pkg::*;
    import idle_report_scoreboard_pkg::*;

    localparam int PHASES           = 7;
    localparam int ITEMS_PER_PHASE  = 160;
    localparam int HOLD_CYCLES      = 64;
    localparam int SETTLE_CYCLES    = 4;
    localparam int RESET_CYCLES     = 10;
    localparam int TIMEOUT_NS       = 2000000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [TICK_W-1:0]      i_tick_delta = '0;
    logic [KBD_W-1:0]       i_keyboard_report = '0;
    logic [7:0]             i_mouse_buttons = '0;
    logic signed [7:0]      i_mouse_dx = '0;
    logic signed [7:0]      i_mouse_dy = '0;
    logic signed [7:0]      i_mouse_scroll = '0;
    logic                   i_keyboard_endpoint_ready = 1'b0;
    logic                   i_mouse_endpoint_ready = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_keyboard_send;
    logic [KBD_W-1:0]       o_keyboard_payload;
    logic                   o_mouse_send;
    logic [MOUSE_W-1:0]     o_mouse_payload;
    logic [MILLIS_W-1:0]    o_millis_increment;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    idle_report_scoreboard sb;
    t_report_result        seen_report;
    bit                    calm = 1'b0;
    bit                    hold_request = 1'b0;

    // Last reports offered, so random requests often repeat them.
    logic [KBD_W-1:0]      last_kbd = '0;
    logic [7:0]            last_buttons = '0;

    hid_report_idle_scheduler_core dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_in_valid                (i_in_valid),
        .o_in_stall                (o_in_stall),
        .i_tick_delta              (i_tick_delta),
        .i_keyboard_report         (i_keyboard_report),
        .i_mouse_buttons           (i_mouse_buttons),
        .i_mouse_dx                (i_mouse_dx),
        .i_mouse_dy                (i_mouse_dy),
        .i_mouse_scroll            (i_mouse_scroll),
        .i_keyboard_endpoint_ready (i_keyboard_endpoint_ready),
        .i_mouse_endpoint_ready    (i_mouse_endpoint_ready),
        .o_out_valid               (o_out_valid),
        .i_out_stall               (i_out_stall),
        .o_keyboard_send           (o_keyboard_send),
        .o_keyboard_payload        (o_keyboard_payload),
        .o_mouse_send              (o_mouse_send),
        .o_mouse_payload           (o_mouse_payload),
        .o_millis_increment        (o_millis_increment),
        .i_cfg_we                  (i_cfg_we),
        .i_cfg_index               (i_cfg_index),
        .i_cfg_data                (i_cfg_data)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // Every result taken by the bench goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_report.keyboard_send    = o_keyboard_send;
            seen_report.keyboard_payload = o_keyboard_payload;
            seen_report.mouse_send       = o_mouse_send;
            seen_report.mouse_payload    = o_mouse_payload;
            seen_report.millis_increment = o_millis_increment;
            sb.check_report(seen_report);
        end
    end

    // Receiver back-pressure: random bursts, one long hold on request,
    // and none once the run turns calm.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
                if (!calm) begin
                    repeat ($urandom_range(0, 15)) @(negedge i_clk);
                end
            end
        end
    end

    function automatic t_poll_item poll_of(logic [TICK_W-1:0] ticks, logic [KBD_W-1:0] kbd,
                                           logic [7:0] buttons, logic [7:0] dx,
                                           logic [7:0] dy, logic [7:0] wheel,
                                           logic kbd_ready, logic mouse_ready);
        t_poll_item p;
        p.tick_delta              = ticks;
        p.keyboard_report         = kbd;
        p.mouse_buttons           = buttons;
        p.mouse_dx                = dx;
        p.mouse_dy                = dy;
        p.mouse_scroll            = wheel;
        p.keyboard_endpoint_ready = kbd_ready;
        p.mouse_endpoint_ready    = mouse_ready;
        return p;
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_poll(t_poll_item p);
        @(negedge i_clk);
        i_in_valid                = 1'b1;
        i_tick_delta              = p.tick_delta;
        i_keyboard_report         = p.keyboard_report;
        i_mouse_buttons           = p.mouse_buttons;
        i_mouse_dx                = p.mouse_dx;
        i_mouse_dy                = p.mouse_dy;
        i_mouse_scroll            = p.mouse_scroll;
        i_keyboard_endpoint_ready = p.keyboard_endpoint_ready;
        i_mouse_endpoint_ready    = p.mouse_endpoint_ready;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_poll(p);
    endtask

    task automatic pause_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Stop sending and wait until every expected result is in, plus the
    // block's latency so nothing is still in flight.
    task automatic wait_for_reports();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        sb.set_rate(index, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random request: mostly repeated reports so idle repeats fire, with
    // changes, bit flips and movement mixed in.
    task automatic next_random_poll(output t_poll_item p);
        int unsigned pick;

        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            p.tick_delta = TICK_W'($urandom_range(0, 1000));
        end else if (pick < 7) begin
            p.tick_delta = TICK_W'($urandom_range(0, 65535));
        end else if (pick < 9) begin
            p.tick_delta = TICK_W'($urandom_range(60000, 65535));
        end else begin
            p.tick_delta = TICK_W'($urandom_range(0, 300));
        end

        pick = $urandom_range(0, 9);
        if (pick >= 8) begin
            last_kbd = last_kbd ^ (64'd1 << $urandom_range(0, 63));
        end else if (pick >= 6) begin
            last_kbd = {$urandom, $urandom};
        end
        p.keyboard_report = last_kbd;

        pick = $urandom_range(0, 9);
        p.mouse_dx     = '0;
        p.mouse_dy     = '0;
        p.mouse_scroll = '0;
        if (pick >= 5) begin
            last_buttons = 8'($urandom);
        end
        if (pick >= 7) begin
            p.mouse_dx     = 8'($urandom);
            p.mouse_dy     = 8'($urandom);
            p.mouse_scroll = 8'($urandom);
        end
        p.mouse_buttons = last_buttons;

        p.keyboard_endpoint_ready = ($urandom_range(0, 3) != 0);
        p.mouse_endpoint_ready    = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        t_poll_item     p;
        logic [7:0]     kbd_rate_plan [PHASES];
        logic [7:0]     mouse_rate_plan [PHASES];

        sb = new();
        kbd_rate_plan   = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0};
        mouse_rate_plan = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd1, 8'd0};
        kbd_rate_plan[3]   = 8'($urandom_range(0, 255));
        mouse_rate_plan[3] = 8'($urandom_range(0, 255));
        kbd_rate_plan[6]   = 8'($urandom_range(1, 64));
        mouse_rate_plan[6] = 8'($urandom_range(1, 64));

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: tick conversion edges with both idle rates at zero.
        send_poll(poll_of(16'd0, '0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_poll(poll_of(16'd249, '0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_poll(poll_of(16'd1, '0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_poll(poll_of(16'd249, '0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        // Tick sum saturates twice in a row.
        send_poll(poll_of(16'hFFFF, '0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_poll(poll_of(16'hFFFF, '0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));

        // Keyboard: all-ones report, then a pending report held while busy.
        send_poll(poll_of(16'd0, '1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_poll(poll_of(16'd0, '0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        send_poll(poll_of(16'd0, 64'h0123_4567_89AB_CDEF, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b1));
        send_poll(poll_of(16'd0, 64'hFEDC_BA98_7654_3210, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b1));

        // Mouse: extreme movement while busy, then sent, then sent again.
        send_poll(poll_of(16'd0, '0, 8'hFF, 8'h7F, 8'h80, 8'hFF, 1'b1, 1'b0));
        send_poll(poll_of(16'd0, '0, 8'hFF, 8'h7F, 8'h80, 8'hFF, 1'b1, 1'b1));
        send_poll(poll_of(16'd0, '0, 8'hFF, 8'h7F, 8'h80, 8'hFF, 1'b1, 1'b1));
        // Button change without movement, then no change at a zero idle rate.
        send_poll(poll_of(16'd0, '0, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_poll(poll_of(16'd0, '0, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));

        // Idle repeat: keyboard every 4 ms, mouse at the longest period.
        wait_for_reports();
        write_rate(REG_KEYBOARD_IDLE_RATE, 8'd1);
        write_rate(REG_MOUSE_IDLE_RATE, 8'd255);
        repeat (3) begin
            send_poll(poll_of(16'd1000, '0, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        end
        repeat (5) begin
            send_poll(poll_of(16'hFFFF, '0, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        end

        // Random phases, one rate setting each; the last runs without stalls or pauses.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_reports();
            write_rate(REG_KEYBOARD_IDLE_RATE, kbd_rate_plan[ph]);
            write_rate(REG_MOUSE_IDLE_RATE, mouse_rate_plan[ph]);
            calm = (ph == PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 1 && n == 40) begin
                    hold_request = 1'b1;
                end
                if (ph == 2 && n == 80) begin
                    wait_for_reports();
                end
                next_random_poll(p);
                send_poll(p);
                if (!calm && $urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 10));
                end
            end
        end

        wait_for_reports();
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
